// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cluster tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OKM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OKM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/okm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okm_pkg
// Types and constants shared by the online k-means cluster tracker.
// ----------------------------------------------------------------------------
package okm_pkg;

   localparam int CLUSTER_W  = 3;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam int CC_W       = 4;
   localparam int GAIN_REG_W = 17;
   localparam int MINS_W     = 16;

   typedef logic [CLUSTER_W-1:0] cluster_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_GAIN      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES   = 2'd2;

   // reset values of the registers
   localparam logic [CC_W-1:0]       CC_RESET   = 4'd4;
   localparam logic [GAIN_REG_W-1:0] GAIN_RESET = 17'd6554;
   localparam logic [MINS_W-1:0]     MINS_RESET = 16'd10;

   // sequencer to scale unit
   typedef struct packed {
      logic load_lo;
      logic load_hi;
   } scale_ctrl_type;

endpackage

// ===== rtl/okm_cen_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okm_cen_mem
// Centroid store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module okm_cen_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/okm_diff_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okm_diff_unit
// Shared subtract unit: sample minus centroid, as sign and magnitude.
// ----------------------------------------------------------------------------
module okm_diff_unit #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] centroid,
   output logic                   diff_neg,
   output logic [SAMPLE_BITS-1:0] diff_mag
);

   localparam int DW = SAMPLE_BITS + 1;

   logic [DW-1:0] diff;
   logic [DW-1:0] mag_full;

   assign diff     = {sample[SAMPLE_BITS-1], sample} - {centroid[SAMPLE_BITS-1], centroid};
   assign diff_neg = diff[DW-1];
   // |diff| never exceeds 2^SAMPLE_BITS - 1, so the top bit drops
   assign mag_full = diff_neg ? (~diff + DW'(1)) : diff;
   assign diff_mag = mag_full[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/okm_scale_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okm_scale_unit
// Gain step: magnitude times gain in two partial products, then floor or
// ceil shift by the gain fraction depending on sign.
// ----------------------------------------------------------------------------
module okm_scale_unit #(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                    clock,
   input  okm_pkg::scale_ctrl_type ctrl,
   input  logic [SAMPLE_BITS-1:0]  mag,
   input  logic                    neg,
   input  logic [GAIN_FRAC_BITS:0] gain,
   output logic [SAMPLE_BITS-1:0]  step
);

   localparam int GW   = GAIN_FRAC_BITS + 1;
   localparam int LO_W = (GW + 1) / 2;
   localparam int HI_W = GW - LO_W;
   localparam int PW   = SAMPLE_BITS + GW;
   localparam logic [PW-1:0] RND = {{(SAMPLE_BITS + 1){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

   logic [SAMPLE_BITS+LO_W-1:0] lo_prod;
   logic [SAMPLE_BITS+HI_W-1:0] hi_prod;
   logic [PW-1:0]               acc_ff;
   logic [PW-1:0]               acc_in;
   logic [PW-1:0]               rounded;

   assign lo_prod = {{LO_W{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, gain[LO_W-1:0]};
   assign hi_prod = {{HI_W{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, gain[GW-1:LO_W]};

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load_lo) begin
         acc_in = {{HI_W{1'b0}}, lo_prod};
      end else if (ctrl.load_hi) begin
         acc_in = acc_ff + {hi_prod, {LO_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // negative moves round the magnitude up, so the signed step is a floor
   assign rounded = acc_ff + (neg ? RND : '0);
   assign step    = rounded[GAIN_FRAC_BITS +: SAMPLE_BITS];

endmodule

// ===== rtl/online_kmeans_cluster_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// online_kmeans_cluster_tracker_top
// Flow: a clear or seeding-only word goes from ST_IDLE to ST_OUT; a classified
//   word (k centroids in use) goes ST_SCAN, ST_MUL_LO, ST_MUL_HI, ST_UPDATE, ST_OUT.
// One word at a time: req_stall is high outside ST_IDLE. The scan reads one
//   centroid a cycle from the store's read port.
// Reset: synchronous; registers return to defaults, seeding restarts, counters clear.
// ----------------------------------------------------------------------------
module online_kmeans_cluster_tracker_top #(
   parameter int K_MAX          = 8,
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [okm_pkg::CLUSTER_W-1:0]       rsp_chosen_cluster,
   output logic                                rsp_change_flag,
   output logic [okm_pkg::CLUSTER_W-1:0]       rsp_previous_cluster,
   output logic signed [SAMPLE_BITS-1:0]       rsp_centroid_value,
   output logic [okm_pkg::COUNT_W-1:0]         rsp_change_count,
   output logic [okm_pkg::COUNT_W-1:0]         rsp_record_count,
   input  logic                                csr_we,
   input  logic [okm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [okm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(K_MAX);
   localparam int CNT_W = $clog2(K_MAX + 1);
   localparam int GW    = GAIN_FRAC_BITS + 1;
   localparam logic [31:0] GAIN_ONE32 = 32'd1 << GAIN_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_UPDATE,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [okm_pkg::CC_W-1:0]       cluster_count_ff, cluster_count_in;
   logic [okm_pkg::GAIN_REG_W-1:0] ema_gain_ff, ema_gain_in;
   logic [okm_pkg::MINS_W-1:0]     min_samples_ff, min_samples_in;

   logic [CNT_W-1:0]          seed_count_ff, seed_count_in;
   logic                      seeded_ff, seeded_in;
   logic [IDX_W-1:0]          last_cluster_ff, last_cluster_in;
   okm_pkg::count_type        change_total_ff, change_total_in;
   okm_pkg::count_type        record_total_ff, record_total_in;

   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]    best_mag_ff, best_mag_in;
   logic                      best_neg_ff, best_neg_in;
   logic [SAMPLE_BITS-1:0]    best_cen_ff, best_cen_in;
   logic [IDX_W-1:0]          winner_ff, winner_in;

   okm_pkg::cluster_type      res_active_ff, res_active_in;
   logic                      res_change_ff, res_change_in;
   okm_pkg::cluster_type      res_prev_ff, res_prev_in;
   logic [SAMPLE_BITS-1:0]    res_cen_ff, res_cen_in;
   okm_pkg::count_type        res_chg_cnt_ff, res_chg_cnt_in;
   okm_pkg::count_type        res_rec_cnt_ff, res_rec_cnt_in;

   okm_pkg::cluster_type      rsp_active_ff, rsp_active_in;
   logic                      rsp_change_ff, rsp_change_in;
   okm_pkg::cluster_type      rsp_prev_ff, rsp_prev_in;
   logic [SAMPLE_BITS-1:0]    rsp_cen_ff, rsp_cen_in;
   okm_pkg::count_type        rsp_chg_cnt_ff, rsp_chg_cnt_in;
   okm_pkg::count_type        rsp_rec_cnt_ff, rsp_rec_cnt_in;

   // store and shared units
   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   logic [SAMPLE_BITS-1:0]    mem_wr_data;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   logic [SAMPLE_BITS-1:0]    mem_rd_data;
   logic                      diff_neg;
   logic [SAMPLE_BITS-1:0]    diff_mag;
   okm_pkg::scale_ctrl_type   scale_ctrl;
   logic [SAMPLE_BITS-1:0]    scale_step;

   logic [CNT_W-1:0]          k_use;
   logic [GW-1:0]             gain_use;
   logic                      req_acc;
   logic [CNT_W-1:0]          seed_next;
   okm_pkg::count_type        rec_sat;
   okm_pkg::count_type        chg_sat;
   logic [okm_pkg::COUNT_W:0] rec_plus;
   logic                      change_hit;
   logic [SAMPLE_BITS-1:0]    new_cen;

   okm_cen_mem #(
      .DEPTH (K_MAX),
      .WIDTH (SAMPLE_BITS)
   ) u_cen_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   okm_diff_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_diff (
      .sample   (sample_ff),
      .centroid (mem_rd_data),
      .diff_neg (diff_neg),
      .diff_mag (diff_mag)
   );

   okm_scale_unit #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_scale (
      .clock (clock),
      .ctrl  (scale_ctrl),
      .mag   (best_mag_ff),
      .neg   (best_neg_ff),
      .gain  (gain_use),
      .step  (scale_step)
   );

   // effective k and gain
   always_comb begin
      if (cluster_count_ff == '0) begin
         k_use = CNT_W'(1);
      end else if (int'(cluster_count_ff) > K_MAX) begin
         k_use = CNT_W'(K_MAX);
      end else begin
         k_use = CNT_W'(cluster_count_ff);
      end
      if (32'(ema_gain_ff) > GAIN_ONE32) begin
         gain_use = GW'(GAIN_ONE32);
      end else begin
         gain_use = GW'(ema_gain_ff);
      end
   end

   assign req_acc    = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign seed_next  = seed_count_ff + CNT_W'(1);
   assign rec_sat    = (&record_total_ff) ? record_total_ff : record_total_ff + 32'd1;
   assign chg_sat    = (&change_total_ff) ? change_total_ff : change_total_ff + 32'd1;
   assign rec_plus   = {1'b0, record_total_ff} + 33'd1;
   assign change_hit = (rec_plus >= {17'b0, min_samples_ff}) && (winner_ff != last_cluster_ff);
   assign new_cen    = best_neg_ff ? (best_cen_ff - scale_step) : (best_cen_ff + scale_step);

   always_comb begin
      state_in         = state_ff;
      cluster_count_in = cluster_count_ff;
      ema_gain_in      = ema_gain_ff;
      min_samples_in   = min_samples_ff;
      seed_count_in    = seed_count_ff;
      seeded_in        = seeded_ff;
      last_cluster_in  = last_cluster_ff;
      change_total_in  = change_total_ff;
      record_total_in  = record_total_ff;
      rd_idx_in        = rd_idx_ff;
      cmp_vld_in       = 1'b0;
      cmp_idx_in       = cmp_idx_ff;
      sample_in        = sample_ff;
      best_mag_in      = best_mag_ff;
      best_neg_in      = best_neg_ff;
      best_cen_in      = best_cen_ff;
      winner_in        = winner_ff;
      res_active_in    = res_active_ff;
      res_change_in    = res_change_ff;
      res_prev_in      = res_prev_ff;
      res_cen_in       = res_cen_ff;
      res_chg_cnt_in   = res_chg_cnt_ff;
      res_rec_cnt_in   = res_rec_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_active_in    = rsp_active_ff;
      rsp_change_in    = rsp_change_ff;
      rsp_prev_in      = rsp_prev_ff;
      rsp_cen_in       = rsp_cen_ff;
      rsp_chg_cnt_in   = rsp_chg_cnt_ff;
      rsp_rec_cnt_in   = rsp_rec_cnt_ff;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = seed_count_ff[IDX_W-1:0];
      mem_wr_data      = req_sample;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = rd_idx_ff[IDX_W-1:0];
      scale_ctrl       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               sample_in = req_sample;
               if (req_cmd == okm_pkg::CMD_CLEAR) begin
                  seed_count_in   = '0;
                  seeded_in       = 1'b0;
                  last_cluster_in = '0;
                  change_total_in = '0;
                  record_total_in = '0;
                  res_active_in   = '0;
                  res_change_in   = 1'b0;
                  res_prev_in     = '0;
                  res_cen_in      = '0;
                  res_chg_cnt_in  = '0;
                  res_rec_cnt_in  = '0;
                  state_in        = ST_OUT;
               end else if (!seeded_ff) begin
                  mem_wr_en     = 1'b1;
                  seed_count_in = seed_next;
                  rd_idx_in     = '0;
                  if (seed_next >= k_use) begin
                     // last seed is also classified
                     seeded_in       = 1'b1;
                     last_cluster_in = '0;
                     state_in        = ST_SCAN;
                  end else begin
                     record_total_in = rec_sat;
                     res_active_in   = '0;
                     res_change_in   = 1'b0;
                     res_prev_in     = '0;
                     res_cen_in      = '0;
                     res_chg_cnt_in  = change_total_ff;
                     res_rec_cnt_in  = rec_sat;
                     state_in        = ST_OUT;
                  end
               end else begin
                  rd_idx_in = '0;
                  state_in  = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // read centroid i while comparing centroid i-1
            if (rd_idx_ff < k_use) begin
               mem_rd_en  = 1'b1;
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
            end
            if (cmp_vld_ff) begin
               if ((cmp_idx_ff == '0) || (diff_mag < best_mag_ff)) begin
                  best_mag_in = diff_mag;
                  best_neg_in = diff_neg;
                  best_cen_in = mem_rd_data;
                  winner_in   = cmp_idx_ff[IDX_W-1:0];
               end
               if (CNT_W'(cmp_idx_ff + CNT_W'(1)) == k_use) begin
                  state_in = ST_MUL_LO;
               end
            end
         end

         ST_MUL_LO: begin
            scale_ctrl.load_lo = 1'b1;
            state_in           = ST_MUL_HI;
         end

         ST_MUL_HI: begin
            scale_ctrl.load_hi = 1'b1;
            state_in           = ST_UPDATE;
         end

         ST_UPDATE: begin
            mem_wr_en       = 1'b1;
            mem_wr_addr     = winner_ff;
            mem_wr_data     = new_cen;
            record_total_in = rec_sat;
            res_active_in   = okm_pkg::cluster_type'(winner_ff);
            res_change_in   = change_hit;
            res_cen_in      = new_cen;
            res_rec_cnt_in  = rec_sat;
            if (change_hit) begin
               change_total_in = chg_sat;
               last_cluster_in = winner_ff;
               res_prev_in     = okm_pkg::cluster_type'(last_cluster_ff);
               res_chg_cnt_in  = chg_sat;
            end else begin
               res_prev_in    = '0;
               res_chg_cnt_in = change_total_ff;
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_active_in  = res_active_ff;
               rsp_change_in  = res_change_ff;
               rsp_prev_in    = res_prev_ff;
               rsp_cen_in     = res_cen_ff;
               rsp_chg_cnt_in = res_chg_cnt_ff;
               rsp_rec_cnt_in = res_rec_cnt_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes restart seeding; counters stay
      if (csr_we) begin
         case (csr_index)
            okm_pkg::CSR_CLUSTER_COUNT: begin
               cluster_count_in = csr_wdata[okm_pkg::CC_W-1:0];
               seed_count_in    = '0;
               seeded_in        = 1'b0;
               last_cluster_in  = '0;
            end
            okm_pkg::CSR_EMA_GAIN: begin
               ema_gain_in     = csr_wdata[okm_pkg::GAIN_REG_W-1:0];
               seed_count_in   = '0;
               seeded_in       = 1'b0;
               last_cluster_in = '0;
            end
            okm_pkg::CSR_MIN_SAMPLES: begin
               min_samples_in  = csr_wdata[okm_pkg::MINS_W-1:0];
               seed_count_in   = '0;
               seeded_in       = 1'b0;
               last_cluster_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cluster_count_ff <= okm_pkg::CC_RESET;
         ema_gain_ff      <= okm_pkg::GAIN_RESET;
         min_samples_ff   <= okm_pkg::MINS_RESET;
         seed_count_ff    <= '0;
         seeded_ff        <= 1'b0;
         last_cluster_ff  <= '0;
         change_total_ff  <= '0;
         record_total_ff  <= '0;
         rd_idx_ff        <= '0;
         cmp_vld_ff       <= 1'b0;
         cmp_idx_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cluster_count_ff <= cluster_count_in;
         ema_gain_ff      <= ema_gain_in;
         min_samples_ff   <= min_samples_in;
         seed_count_ff    <= seed_count_in;
         seeded_ff        <= seeded_in;
         last_cluster_ff  <= last_cluster_in;
         change_total_ff  <= change_total_in;
         record_total_ff  <= record_total_in;
         rd_idx_ff        <= rd_idx_in;
         cmp_vld_ff       <= cmp_vld_in;
         cmp_idx_ff       <= cmp_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      sample_ff      <= sample_in;
      best_mag_ff    <= best_mag_in;
      best_neg_ff    <= best_neg_in;
      best_cen_ff    <= best_cen_in;
      winner_ff      <= winner_in;
      res_active_ff  <= res_active_in;
      res_change_ff  <= res_change_in;
      res_prev_ff    <= res_prev_in;
      res_cen_ff     <= res_cen_in;
      res_chg_cnt_ff <= res_chg_cnt_in;
      res_rec_cnt_ff <= res_rec_cnt_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_change_ff  <= rsp_change_in;
      rsp_prev_ff    <= rsp_prev_in;
      rsp_cen_ff     <= rsp_cen_in;
      rsp_chg_cnt_ff <= rsp_chg_cnt_in;
      rsp_rec_cnt_ff <= rsp_rec_cnt_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_cluster   = rsp_active_ff;
   assign rsp_change_flag      = rsp_change_ff;
   assign rsp_previous_cluster = rsp_prev_ff;
   assign rsp_centroid_value   = rsp_cen_ff;
   assign rsp_change_count     = rsp_chg_cnt_ff;
   assign rsp_record_count     = rsp_rec_cnt_ff;

endmodule

// ===== rtl/okm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okm_checker
// Port-level checks on the cluster tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module okm_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [okm_pkg::CLUSTER_W-1:0]     rsp_previous_cluster,
   input logic                              rsp_change_flag,
   input logic [SAMPLE_BITS-1:0]            rsp_centroid_value,
   input logic [okm_pkg::COUNT_W-1:0]       rsp_change_count,
   input logic [okm_pkg::COUNT_W-1:0]       rsp_record_count
);

   `OKM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "block took a second word without processing the first")
   `OKM_ASSERT_IMP(a_prev_zero, clock, reset, rsp_valid && !rsp_change_flag, rsp_previous_cluster == '0, "previous cluster set without a change")
   `OKM_ASSERT_IMP(a_chg_le_rec, clock, reset, rsp_valid, rsp_change_count <= rsp_record_count, "more changes than records")
   `OKM_ASSERT_IMP(a_chg_counted, clock, reset, rsp_valid && rsp_change_flag, rsp_change_count != '0, "change flagged but change count is zero")
   `OKM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_centroid_value) && $stable(rsp_record_count), "stalled result word changed")

endmodule

bind online_kmeans_cluster_tracker_top okm_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_okm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_previous_cluster (rsp_previous_cluster),
   .rsp_change_flag      (rsp_change_flag),
   .rsp_centroid_value   (rsp_centroid_value),
   .rsp_change_count     (rsp_change_count),
   .rsp_record_count     (rsp_record_count)
);
